// File: hw/rtl/ppbs_pkg.sv
// Shared types and constants for the projected point box select block.
// No dependencies.
`timescale 1ns / 1ps
package ppbs_pkg;
    localparam int unsigned MaxRunPointsDefault = 1048576;
    localparam int unsigned IndexWidth = 20;
    localparam int unsigned CountWidth = 17;
    localparam int unsigned CfgIdxWidth = 3;

    localparam logic [CfgIdxWidth-1:0] CfgRow0  = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CfgRow1  = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CfgRow2  = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CfgRow3  = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CfgRect  = 3'd4;
    localparam logic [CfgIdxWidth-1:0] CfgLimit = 3'd5;

    localparam logic [63:0] Row0Reset  = 64'd4096;
    localparam logic [63:0] Row1Reset  = 64'd268435456;
    localparam logic [63:0] Row2Reset  = 64'd17592186044416;
    localparam logic [63:0] Row3Reset  = 64'd1152921504606846976;
    localparam logic [15:0] LimitReset = 16'd100;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               last_point;
    } t_in_item;

    typedef struct packed {
        logic [IndexWidth-1:0] point_index;
        logic                  selected;
        logic [CountWidth-1:0] selected_count;
        logic                  over_limit;
        logic                  last_result;
    } t_out_item;

    // front to back: classification of one point
    typedef struct packed {
        logic selected;
        logic last_point;
    } t_class;

    typedef struct packed {
        logic [63:0] row0;
        logic [63:0] row1;
        logic [63:0] row2;
        logic [63:0] row3;
        logic [63:0] rect;
    } t_geom;

    function automatic logic signed [15:0] coef(input logic [63:0] row, input int j);
        coef = row[16*j +: 16];
    endfunction
endpackage

// File: hw/rtl/ppbs_front.sv
// Front part: projection pipeline and box test, one point per cycle while i_advance is high.
// Depends on ppbs_pkg.
`timescale 1ns / 1ps
module ppbs_front import ppbs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_geom    i_geom,
    input  logic     i_valid,
    input  t_in_item i_item,
    input  logic     i_advance,
    output logic     o_valid,
    output t_class   o_class
);
    // stage 1: 12 products and 4 offset terms; stage 2: row sums; stage 3:
    // sign fix; stage 4: scaled coordinates and bounds, then compares
    logic               r_v1, r_v2, r_v3, r_v4;
    logic               r_l1, r_l2, r_l3, r_l4;
    logic signed [47:0] r_p [4][4];
    logic signed [49:0] r_c [4];
    logic signed [49:0] r_n [3];
    logic signed [49:0] r_w;
    logic               r_wz;
    logic signed [15:0] r_b [4];
    logic signed [63:0] r_xs, r_ys, r_lw, r_rw, r_yl, r_yh;
    logic signed [49:0] r_z3, r_w3;
    logic               r_wz3;
    logic               r_sel;
    logic signed [49:0] n_c [4];

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            n_c[r] = 50'(r_p[r][0]) + 50'(r_p[r][1]) + 50'(r_p[r][2]) + 50'(r_p[r][3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
        end else if (i_advance) begin
            r_v1 <= i_valid; r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            for (int r = 0; r < 4; r++) begin
                logic [63:0] row;
                row = (r == 0) ? i_geom.row0 : (r == 1) ? i_geom.row1 :
                      (r == 2) ? i_geom.row2 : i_geom.row3;
                r_p[r][0] <= 48'(coef(row, 0) * i_item.point_x);
                r_p[r][1] <= 48'(coef(row, 1) * i_item.point_y);
                r_p[r][2] <= 48'(coef(row, 2) * i_item.point_z);
                r_p[r][3] <= 48'($signed({coef(row, 3), 16'h0000}));
            end
            r_l1 <= i_item.last_point;
            r_c  <= n_c;
            r_l2 <= r_l1;
            r_wz <= (n_c[3] == '0);
            for (int k = 0; k < 3; k++) begin
                r_n[k] <= r_c[3][49] ? -r_c[k] : r_c[k];
            end
            r_w  <= r_c[3][49] ? -r_c[3] : r_c[3];
            r_wz3 <= r_wz;
            for (int k = 0; k < 4; k++) begin
                r_b[k] <= i_geom.rect[16*k +: 16];
            end
            r_l3 <= r_l2;
            r_xs <= 64'(r_n[0]) <<< 14;
            r_ys <= 64'(r_n[1]) <<< 14;
            r_lw <= 64'(r_b[0] * r_w);
            r_rw <= 64'(r_b[1] * r_w);
            r_yl <= 64'(r_b[2] * r_w);
            r_yh <= 64'(r_b[3] * r_w);
            r_z3 <= r_n[2];
            r_w3 <= r_w;
            r_l4 <= r_l3;
            r_sel <= !r_wz3;
        end
    end

    assign o_valid = r_v4;
    assign o_class.last_point = r_l4;
    assign o_class.selected = r_sel && r_xs >= r_lw && r_xs <= r_rw && r_ys >= r_yl
        && r_ys <= r_yh && r_z3 >= -r_w3 && r_z3 <= r_w3;
endmodule

// File: hw/rtl/ppbs_queue.sv
// Short queue between front and back parts.
// Depends on ppbs_pkg.
`timescale 1ns / 1ps
module ppbs_queue import ppbs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_class i_data,
    output logic   o_has_room,
    input  logic   i_pop,
    output logic   o_valid,
    output t_class o_data
);
    // 8 entries; front may hold 4 points in flight, so room means count<=3
    t_class     r_mem [8];
    logic [2:0] r_wp, r_rp;
    logic [3:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 3'd1;
            if (i_pop) r_rp <= r_rp + 3'd1;
            r_cnt <= r_cnt + 4'(i_push) - 4'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_valid    = r_cnt != '0;
    assign o_data     = r_mem[r_rp];
    assign o_has_room = r_cnt <= 4'd3;
endmodule

// File: hw/rtl/ppbs_back.sv
// Back part: run position, hit counter and the result register.
// Depends on ppbs_pkg.
`timescale 1ns / 1ps
module ppbs_back import ppbs_pkg::*; #(
    parameter int unsigned MAX_RUN_POINTS = MaxRunPointsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_limit,
    input  logic        i_valid,
    input  t_class      i_class,
    output logic        o_take,
    output logic        o_empty,
    output t_out_item   o_item,
    input  logic        i_pop
);
    localparam int unsigned PosW = $clog2(MAX_RUN_POINTS);
    logic [PosW-1:0]       r_pos;
    logic [CountWidth-1:0] r_hits, n_hits;
    logic                  r_full;
    t_out_item             r_out;

    assign o_take = i_valid && (!r_full || i_pop);
    assign n_hits = (i_class.selected && r_hits <= CountWidth'(i_limit))
                    ? r_hits + 1'b1 : r_hits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_hits <= '0; r_full <= 1'b0;
        end else begin
            if (o_take) begin
                r_full <= 1'b1;
                if (i_class.last_point) begin
                    r_pos <= '0; r_hits <= '0;
                end else begin
                    r_hits <= n_hits;
                    if (r_pos != PosW'(MAX_RUN_POINTS - 1)) r_pos <= r_pos + 1'b1;
                end
            end else if (i_pop) begin
                r_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out.point_index    <= IndexWidth'(r_pos);
            r_out.selected       <= i_class.selected;
            r_out.selected_count <= n_hits;
            r_out.over_limit     <= n_hits > CountWidth'(i_limit);
            r_out.last_result    <= i_class.last_point;
        end
    end

    assign o_empty = !r_full;
    assign o_item  = r_out;
endmodule

// File: hw/rtl/projected_point_box_select.sv
// Top level: config registers, front/queue/back wiring, assertions.
// Depends on ppbs_pkg, ppbs_front, ppbs_queue, ppbs_back.
`timescale 1ns / 1ps
// Projects each point through the configured 4x4 matrix and tests it
// against the NDC rectangle and depth range with exact fixed-point compares.
// One point per cycle while full is low; each result passes through the
// four-stage projection pipeline, the queue and the result register.
// Config writes are always ready and must be made while the block is idle.
module projected_point_box_select import ppbs_pkg::*; #(
    parameter int unsigned MAX_RUN_POINTS = MaxRunPointsDefault
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  t_in_item               i_item,
    output logic                   empty,
    input  logic                   pop,
    output t_out_item              o_item,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CfgIdxWidth-1:0] i_cfg_index,
    input  logic [63:0]            i_cfg_data
);
    t_geom       r_geom;
    logic [15:0] r_limit;
    logic        room, fr_valid, q_valid, take;
    t_class      fr_class, q_class;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom  <= '{Row0Reset, Row1Reset, Row2Reset, Row3Reset, 64'd0};
            r_limit <= LimitReset;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CfgRow0:  r_geom.row0 <= i_cfg_data;
                CfgRow1:  r_geom.row1 <= i_cfg_data;
                CfgRow2:  r_geom.row2 <= i_cfg_data;
                CfgRow3:  r_geom.row3 <= i_cfg_data;
                CfgRect:  r_geom.rect <= i_cfg_data;
                CfgLimit: r_limit     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign full = !room;

    ppbs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_geom(r_geom),
        .i_valid(push && room), .i_item(i_item), .i_advance(1'b1),
        .o_valid(fr_valid), .o_class(fr_class)
    );

    ppbs_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(fr_valid), .i_data(fr_class),
        .o_has_room(room), .i_pop(take), .o_valid(q_valid), .o_data(q_class)
    );

    ppbs_back #(.MAX_RUN_POINTS(MAX_RUN_POINTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_limit(r_limit), .i_valid(q_valid),
        .i_class(q_class), .o_take(take), .o_empty(empty), .o_item(o_item),
        .i_pop(pop)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_item.selected_count <= 17'(r_limit) + 17'd1)
        else $error("selected count past limit plus one");
    a_over_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_item.over_limit == (o_item.selected_count > 17'(r_limit)))
        else $error("over_limit disagrees with count");
    a_run_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && q_class.last_point |=> u_back.r_pos == '0)
        else $error("run position not cleared after last point");
`endif
endmodule
